// ===== hw/rtl/i2cm_pkg.sv =====
package i2cm_pkg;

  // Command codes carried in the input tuser field
  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;
  localparam logic [3:0] BITS_PER_BYTE   = 4'd8;

  typedef enum logic [18:0] {
    P_IDLE   = 19'b1 << 0,
    P_ST_HI  = 19'b1 << 1,
    P_ST_LO  = 19'b1 << 2,
    P_SP_LO  = 19'b1 << 3,
    P_SP_CK  = 19'b1 << 4,
    P_SP_DA  = 19'b1 << 5,
    P_W_LOW  = 19'b1 << 6,
    P_W_DAT  = 19'b1 << 7,
    P_W_HI   = 19'b1 << 8,
    P_A_REL  = 19'b1 << 9,
    P_A_HI   = 19'b1 << 10,
    P_A_POLL = 19'b1 << 11,
    P_A_HOLD = 19'b1 << 12,
    P_R_LOW  = 19'b1 << 13,
    P_R_HI   = 19'b1 << 14,
    P_R_SMP  = 19'b1 << 15,
    P_K_LOW  = 19'b1 << 16,
    P_K_DAT  = 19'b1 << 17,
    P_K_HI   = 19'b1 << 18
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    logic [3:0] bit_count;
    logic [7:0] shift_reg;
    logic [1:0] unit_wait;
    logic [7:0] timeout_count;
    logic       ack_choice;
    logic       scl;
    logic       sda;
    logic       sda_drive;
    logic       fail;
    logic [7:0] rx_last;
  } state_t;

endpackage

// ===== hw/rtl/i2c_master_byte_engine_top.sv =====
// The result beat for an accepted tick beat is registered and valid in the cycle after it is accepted.
// Throughput: one tick beat per cycle while m_axis_tready is high; the bus phase sequencer advances once
// per accepted beat and the output register lets the next beat in while the
// current result is still being taken.
// Reset (rst, synchronous): engine idle, SCL and SDA driven high, ack_timeout 250.
module i2c_master_byte_engine_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // tx_data[7:0], send_ack[8], sda_in[9], zero [15:10]
  input  logic [2:0]  s_axis_tuser,  // cmd[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // scl_level[0], sda_level[1], sda_drive[2], busy_res[3], done_res[4],
  // rx_byte[12:5], ack_failed[13], zero [15:14]
  output logic [15:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data       // ack_timeout
);
  import i2cm_pkg::*;

  state_t     st;
  state_t     st_next;
  logic       done;
  logic [7:0] ack_timeout;
  logic       in_beat;

  assign s_axis_tready = ~m_axis_tvalid | m_axis_tready;
  assign in_beat       = s_axis_tvalid & s_axis_tready;
  assign cfg_ready     = 1'b1;

  i2cm_step u_step (
    .st          (st),
    .cmd         (s_axis_tuser),
    .tx_data     (s_axis_tdata[7:0]),
    .send_ack    (s_axis_tdata[8]),
    .sda_in      (s_axis_tdata[9]),
    .ack_timeout (ack_timeout),
    .st_next     (st_next),
    .done        (done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_timeout <= ACK_TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      ack_timeout <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase         <= P_IDLE;
      st.bit_count     <= '0;
      st.shift_reg     <= '0;
      st.unit_wait     <= '0;
      st.timeout_count <= '0;
      st.ack_choice    <= 1'b0;
      st.scl           <= 1'b1;
      st.sda           <= 1'b1;
      st.sda_drive     <= 1'b1;
      st.fail          <= 1'b0;
      st.rx_last       <= '0;
    end else if (in_beat) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_beat) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // result payload, loaded with each accepted tick
  always_ff @(posedge clk) begin
    if (in_beat) begin
      m_axis_tdata <= {2'b00, st_next.fail, st_next.rx_last, done,
                       st_next.phase != P_IDLE, st_next.sda_drive,
                       st_next.sda, st_next.scl};
    end
  end

  a_done_not_busy : assert property (@(posedge clk) disable iff (rst)
    in_beat && done |-> st_next.phase == P_IDLE)
    else $error("done raised while the engine stays busy");

  a_beat_loaded : assert property (@(posedge clk) disable iff (rst)
    in_beat |=> m_axis_tvalid)
    else $error("accepted tick produced no result beat");

  a_idle_no_wait : assert property (@(posedge clk) disable iff (rst)
    st.phase == P_IDLE |-> st.unit_wait == 2'd0)
    else $error("idle with a pending phase wait");

endmodule

// ===== hw/rtl/i2cm_step.sv =====
module i2cm_step (
  input  i2cm_pkg::state_t st,
  input  logic [2:0]       cmd,
  input  logic [7:0]       tx_data,
  input  logic             send_ack,
  input  logic             sda_in,
  input  logic [7:0]       ack_timeout,
  output i2cm_pkg::state_t st_next,
  output logic             done
);
  import i2cm_pkg::*;

  // One tick of ACK polling: low ends the check, too many highs force a stop
  function automatic state_t poll_ack(state_t s, logic sda, logic [7:0] lim);
    state_t     r;
    logic [8:0] t;
    r = s;
    t = {1'b0, s.timeout_count} + 9'd1;
    r.phase = P_A_POLL;
    if (!sda) begin
      r.phase     = P_A_HOLD;
      r.unit_wait = 2'd1;
    end else if (t > {1'b0, lim}) begin
      r.fail      = 1'b1;
      r.sda_drive = 1'b1;
      r.sda       = 1'b0;
      r.scl       = 1'b0;
      r.phase     = P_SP_LO;
      r.unit_wait = 2'd1;
    end else begin
      r.timeout_count = t[7:0];
    end
    return r;
  endfunction

  always_comb begin
    st_next = st;
    done    = 1'b0;
    if (st.phase == P_IDLE) begin
      case (cmd)
        CMD_START: begin
          st_next.sda_drive = 1'b1;
          st_next.sda       = 1'b1;
          st_next.scl       = 1'b1;
          st_next.phase     = P_ST_HI;
          st_next.unit_wait = 2'd1;
        end
        CMD_STOP: begin
          st_next.sda_drive = 1'b1;
          st_next.sda       = 1'b0;
          st_next.scl       = 1'b0;
          st_next.phase     = P_SP_LO;
          st_next.unit_wait = 2'd1;
        end
        CMD_WRITE: begin
          st_next.shift_reg     = tx_data;
          st_next.bit_count     = '0;
          st_next.timeout_count = '0;
          st_next.fail          = 1'b0;
          st_next.sda_drive     = 1'b1;
          st_next.scl           = 1'b0;
          st_next.phase         = P_W_LOW;
          st_next.unit_wait     = 2'd0;
        end
        CMD_READ: begin
          st_next.ack_choice = send_ack;
          st_next.bit_count  = '0;
          st_next.shift_reg  = '0;
          st_next.sda_drive  = 1'b0;
          st_next.scl        = 1'b0;
          st_next.phase      = P_R_LOW;
          st_next.unit_wait  = 2'd1;
        end
        default: ;
      endcase
    end else if (st.phase == P_A_POLL) begin
      st_next = poll_ack(st, sda_in, ack_timeout);
    end else if (st.unit_wait != 2'd0) begin
      st_next.unit_wait = st.unit_wait - 2'd1;
    end else begin
      case (st.phase)
        P_ST_HI: begin
          st_next.sda       = 1'b0;
          st_next.phase     = P_ST_LO;
          st_next.unit_wait = 2'd1;
        end
        P_ST_LO: begin
          st_next.scl   = 1'b0;
          st_next.phase = P_IDLE;
          done          = 1'b1;
        end
        P_SP_LO: begin
          st_next.scl       = 1'b1;
          st_next.phase     = P_SP_CK;
          st_next.unit_wait = 2'd1;
        end
        P_SP_CK: begin
          st_next.sda       = 1'b1;
          st_next.phase     = P_SP_DA;
          st_next.unit_wait = 2'd1;
        end
        P_SP_DA: begin
          st_next.scl   = 1'b1;
          st_next.phase = P_IDLE;
          done          = 1'b1;
        end
        P_W_LOW: begin
          st_next.sda       = st.shift_reg[7];
          st_next.shift_reg = {st.shift_reg[6:0], 1'b0};
          st_next.bit_count = st.bit_count + 4'd1;
          st_next.phase     = P_W_DAT;
        end
        P_W_DAT: begin
          st_next.scl       = 1'b1;
          st_next.phase     = P_W_HI;
          st_next.unit_wait = 2'd1;
        end
        P_W_HI: begin
          st_next.scl = 1'b0;
          if (st.bit_count < BITS_PER_BYTE) begin
            st_next.phase = P_W_LOW;
          end else begin
            // release SDA for the slave ACK
            st_next.sda_drive = 1'b0;
            st_next.phase     = P_A_REL;
            st_next.unit_wait = 2'd1;
          end
        end
        P_A_REL: begin
          st_next.scl   = 1'b1;
          st_next.phase = P_A_HI;
        end
        P_A_HI: st_next = poll_ack(st, sda_in, ack_timeout);
        P_A_HOLD: begin
          st_next.scl   = 1'b0;
          st_next.phase = P_IDLE;
          done          = 1'b1;
        end
        P_R_LOW: begin
          st_next.scl   = 1'b1;
          st_next.phase = P_R_HI;
        end
        P_R_HI: begin
          st_next.shift_reg = {st.shift_reg[6:0], sda_in};
          st_next.bit_count = st.bit_count + 4'd1;
          st_next.phase     = P_R_SMP;
        end
        P_R_SMP: begin
          st_next.scl = 1'b0;
          if (st.bit_count < BITS_PER_BYTE) begin
            st_next.phase     = P_R_LOW;
            st_next.unit_wait = 2'd1;
          end else begin
            st_next.sda_drive = 1'b1;
            st_next.phase     = P_K_LOW;
          end
        end
        P_K_LOW: begin
          st_next.sda   = ~st.ack_choice;
          st_next.phase = P_K_DAT;
        end
        P_K_DAT: begin
          st_next.scl       = 1'b1;
          st_next.phase     = P_K_HI;
          st_next.unit_wait = 2'd1;
        end
        P_K_HI: begin
          st_next.scl     = 1'b0;
          st_next.rx_last = st.shift_reg;
          st_next.phase   = P_IDLE;
          done            = 1'b1;
        end
        default: begin
          st_next.phase     = P_IDLE;
          st_next.unit_wait = 2'd0;
        end
      endcase
    end
  end

endmodule
